// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque with search: action and
// status codes, sequencer states and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   // fixed field widths of the request and response beats
   localparam int ACTION_W  = 3;
   localparam int ITEM_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 4;
   localparam int COUNT_W   = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_FIND       = 3'd4,
      ACT_REMOVE_ONE = 3'd5,
      ACT_REMOVE_ALL = 3'd6,
      ACT_CLEAR      = 3'd7
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_TAKE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_LOOK,
      S_RESULT
   } state_type;

endpackage : bdq_pkg

`default_nettype wire

// ===== hw/rtl/bdq_req_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: one action and its operand value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if
   import bdq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ITEM_W-1:0]   item_value;

   modport source (output valid, output action, output item_value, input ready);
   modport sink   (input valid, input action, input item_value, output ready);
endinterface : bdq_req_if

`default_nettype wire

// ===== hw/rtl/bdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: status, popped value, search results and deque ends.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_rsp_if
   import bdq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ITEM_W-1:0]   taken_value;
   logic [INDEX_W-1:0]  found_index;
   logic [COUNT_W-1:0]  removed_count;
   logic [COUNT_W-1:0]  fill_level;
   logic [ITEM_W-1:0]   front_value;
   logic [ITEM_W-1:0]   back_value;

   modport source (output valid, output status, output taken_value,
                   output found_index, output removed_count, output fill_level,
                   output front_value, output back_value, input ready);
   modport sink   (input valid, input status, input taken_value,
                   input found_index, input removed_count, input fill_level,
                   input front_value, input back_value, output ready);
endinterface : bdq_rsp_if

`default_nettype wire

// ===== hw/rtl/bdq_store.sv =====
// ----------------------------------------------------------------------------
// bdq_store
// Entry memory of the deque: one write port, two read ports, read data
// registered (old data on a same-edge collision).
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output      logic [WIDTH-1:0]         rd_a_data,
   output      logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= entry_ff[rd_a_addr];
      rd_b_ff <= entry_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule : bdq_store

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue in a ring memory, with find, remove-one and
// remove-all (swap with front) by a sequential scan over the held entries.
// ----------------------------------------------------------------------------
// Steps after accept: push, clear and an empty pop or search go to look, then
//   result; a pop reads its word in a take step first; find/remove scan up to
//   the fill level, each scan step a memory read, then compare/write-back.
// Items are taken one at a time; ready returns the cycle after the response
//   register is loaded.
// Reset: synchronous; deque empty, front pointer zero, no response; memory kept.
`default_nettype none

module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   bdq_req_if.sink  req_chan,
   bdq_rsp_if.source rsp_chan
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int VW = VALUE_WIDTH;
   localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // ring wrap of a pointer sum below twice the depth
   function automatic logic [PW-1:0] wrap_slot(input logic [PW:0] sum);
      logic [PW:0] adj;
      adj = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
      return adj[PW-1:0];
   endfunction

   // control state
   state_type     state_ff, state_in;
   logic [PW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   action_type    act_ff, act_in;
   logic [VW-1:0] val_ff, val_in;
   logic [PW-1:0] scan_ff, scan_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [PW-1:0] pos_ff, pos_in;
   status_type    status_ff, status_in;
   logic [VW-1:0] taken_ff, taken_in;
   logic [PW-1:0] found_ff, found_in;
   logic [CW-1:0] removed_ff, removed_in;

   // response register
   status_type         rsp_status_ff, rsp_status_in;
   logic [ITEM_W-1:0]  rsp_taken_ff, rsp_taken_in;
   logic [INDEX_W-1:0] rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [COUNT_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic [ITEM_W-1:0]  rsp_front_ff, rsp_front_in;
   logic [ITEM_W-1:0]  rsp_back_ff, rsp_back_in;

   // memory ports
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic [PW-1:0] rd_a_addr;
   logic [PW-1:0] rd_b_addr;
   logic [VW-1:0] rd_a_data;
   logic [VW-1:0] rd_b_data;

   // pointer arithmetic on the current state
   logic [PW-1:0] front_dec;
   logic [PW-1:0] front_inc;
   logic [PW-1:0] tail_slot;
   logic [PW-1:0] back_slot;
   logic [PW-1:0] scan_inc;
   logic          is_full;
   logic          deque_empty;
   logic          req_beat;
   logic          rsp_free;
   logic          hit;
   action_type    req_act;
   logic [VW-1:0] req_val;

   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
   assign scan_inc  = (scan_ff == LAST_SLOT) ? '0 : scan_ff + 1'b1;
   assign tail_slot = wrap_slot({1'b0, front_ff} + (PW + 1)'(count_ff));
   assign back_slot = deque_empty ? front_ff
                    : wrap_slot({1'b0, front_ff} + (PW + 1)'(count_ff - 1'b1));
   assign is_full     = (count_ff == FULL_COUNT);
   assign deque_empty = (count_ff == '0);
   assign hit       = (rd_a_data == val_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat = req_chan.valid && req_chan.ready;
   assign req_act  = action_type'(req_chan.action);
   assign req_val  = VW'(req_chan.item_value);

   bdq_store #(
      .DEPTH (DEPTH),
      .WIDTH (VW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               case (req_act)
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     state_in = deque_empty ? S_LOOK : S_TAKE;
                  end
                  ACT_FIND, ACT_REMOVE_ONE, ACT_REMOVE_ALL: begin
                     state_in = deque_empty ? S_LOOK : S_SCAN_RD;
                  end
                  default: begin
                     state_in = S_LOOK;
                  end
               endcase
            end
         end
         S_TAKE:    state_in = S_LOOK;
         S_SCAN_RD: state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            if ((hit && act_ff != ACT_REMOVE_ALL) || rem_ff == CW'(1)) begin
               state_in = S_LOOK;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_LOOK:    state_in = S_RESULT;
         S_RESULT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath, memory control and response loading
   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      act_in         = act_ff;
      val_in         = val_ff;
      scan_in        = scan_ff;
      rem_in         = rem_ff;
      pos_in         = pos_ff;
      status_in      = status_ff;
      taken_in       = taken_ff;
      found_in       = found_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_taken_in   = rsp_taken_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_back_in    = rsp_back_ff;
      wr_en          = 1'b0;
      wr_addr        = front_ff;
      wr_data        = req_val;
      rd_a_addr      = front_ff;
      rd_b_addr      = front_ff;

      case (state_ff)
         // take a beat and carry out the push and clear actions
         S_IDLE: begin
            if (req_beat) begin
               act_in     = req_act;
               val_in     = req_val;
               status_in  = ST_OK;
               taken_in   = '0;
               found_in   = '0;
               removed_in = '0;
               scan_in    = front_ff;
               rem_in     = count_ff;
               pos_in     = '0;
               case (req_act)
                  ACT_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_slot;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (deque_empty) begin
                        status_in = ST_EMPTY;
                     end
                     rd_a_addr = front_ff;
                  end
                  ACT_POP_BACK: begin
                     if (deque_empty) begin
                        status_in = ST_EMPTY;
                     end
                     rd_a_addr = back_slot;
                  end
                  ACT_FIND, ACT_REMOVE_ONE, ACT_REMOVE_ALL: begin
                     status_in = ST_MISS;
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         // popped word arrives; unlink it
         S_TAKE: begin
            taken_in = rd_a_data;
            count_in = count_ff - 1'b1;
            if (act_ff == ACT_POP_FRONT) begin
               front_in = front_inc;
            end
         end
         // fetch the scanned entry and the current front
         S_SCAN_RD: begin
            rd_a_addr = scan_ff;
            rd_b_addr = front_ff;
         end
         // compare; a removal overwrites the match with the front word
         S_SCAN_EV: begin
            scan_in = scan_inc;
            rem_in  = rem_ff - 1'b1;
            pos_in  = pos_ff + 1'b1;
            if (hit) begin
               status_in = ST_OK;
               if (act_ff == ACT_FIND) begin
                  found_in = pos_ff;
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = scan_ff;
                  wr_data    = rd_b_data;
                  front_in   = front_inc;
                  count_in   = count_ff - 1'b1;
                  removed_in = removed_ff + 1'b1;
               end
            end
         end
         // read both ends of the deque as it now stands
         S_LOOK: begin
            rd_a_addr = front_ff;
            rd_b_addr = back_slot;
         end
         // load the response register once it is free; ends stay on the read ports
         S_RESULT: begin
            rd_a_addr = front_ff;
            rd_b_addr = back_slot;
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_taken_in   = ITEM_W'(taken_ff);
               rsp_found_in   = INDEX_W'(found_ff);
               rsp_removed_in = COUNT_W'(removed_ff);
               rsp_fill_in    = COUNT_W'(count_ff);
               rsp_front_in   = deque_empty ? '0 : ITEM_W'(rd_a_data);
               rsp_back_in    = deque_empty ? '0 : ITEM_W'(rd_b_data);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      val_ff         <= val_in;
      scan_ff        <= scan_in;
      rem_ff         <= rem_in;
      pos_ff         <= pos_in;
      status_ff      <= status_in;
      taken_ff       <= taken_in;
      found_ff       <= found_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_taken_ff   <= rsp_taken_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_back_ff    <= rsp_back_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.taken_value   = rsp_taken_ff;
   assign rsp_chan.found_index   = rsp_found_ff;
   assign rsp_chan.removed_count = rsp_removed_ff;
   assign rsp_chan.fill_level    = rsp_fill_ff;
   assign rsp_chan.front_value   = rsp_front_ff;
   assign rsp_chan.back_value    = rsp_back_ff;

   // fill level and front pointer stay within the ring
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT && front_ff <= LAST_SLOT)
      else $error("deque pointer or fill level out of range");

   // a new response only comes from the result state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("response loaded outside the result state");

   // memory writes only on a push beat or a scan compare
   a_wr_src: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_IDLE || state_ff == S_SCAN_EV))
      else $error("unexpected memory write");

   // a scan step always has an entry left to examine
   a_scan_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD || state_ff == S_SCAN_EV) |-> rem_ff != '0)
      else $error("scan ran past the held entries");

   // the fill level never moves by more than one outside a clear
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> (count_ff == $past(count_ff)
         || count_ff == $past(count_ff) - 1'b1))
      else $error("fill level jumped during an action");

endmodule : bounded_deque_with_search

`default_nettype wire

// ===== bench/deque_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_scoreboard_pkg
// Predicts the reply of the bounded deque for every accepted request beat and
// checks each reply beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

package deque_scoreboard_pkg;
   import bdq_pkg::*;

   localparam int RING_DEPTH = 16;

   typedef struct packed {
      status_type          status;
      logic [ITEM_W-1:0]   taken_value;
      logic [INDEX_W-1:0]  found_index;
      logic [COUNT_W-1:0]  removed_count;
      logic [COUNT_W-1:0]  fill_level;
      logic [ITEM_W-1:0]   front_value;
      logic [ITEM_W-1:0]   back_value;
   } deque_reply_type;

   class deque_scoreboard;
      // shadow copy of the deque
      logic [ITEM_W-1:0] ring [RING_DEPTH];
      int unsigned       front;
      int unsigned       count;

      deque_reply_type   expected_replies [$];
      int unsigned       error_count;

      function new();
         front       = 0;
         count       = 0;
         error_count = 0;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function int unsigned ring_slot(int unsigned pos);
         return (front + pos) % RING_DEPTH;
      endfunction

      // overwrite the entry at pos with the front, then drop the front
      function void swap_with_front(int unsigned pos);
         ring[ring_slot(pos)] = ring[front];
         front = (front + 1) % RING_DEPTH;
         count--;
      endfunction

      function deque_reply_type predict_reply(action_type act, logic [ITEM_W-1:0] v);
         deque_reply_type r;
         int unsigned  pos;
         bit           hit;
         r        = '0;
         r.status = ST_OK;
         hit      = 1'b0;
         case (act)
            ACT_PUSH_FRONT: begin
               if (count >= RING_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  front       = (front + RING_DEPTH - 1) % RING_DEPTH;
                  ring[front] = v;
                  count++;
               end
            end
            ACT_PUSH_BACK: begin
               if (count >= RING_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  ring[ring_slot(count)] = v;
                  count++;
               end
            end
            ACT_POP_FRONT: begin
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.taken_value = ring[front];
                  front = (front + 1) % RING_DEPTH;
                  count--;
               end
            end
            ACT_POP_BACK: begin
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.taken_value = ring[ring_slot(count - 1)];
                  count--;
               end
            end
            ACT_FIND: begin
               r.status = ST_MISS;
               for (pos = 0; pos < count; pos++) begin
                  if (!hit && ring[ring_slot(pos)] == v) begin
                     hit           = 1'b1;
                     r.status      = ST_OK;
                     r.found_index = INDEX_W'(pos);
                  end
               end
            end
            ACT_REMOVE_ONE: begin
               r.status = ST_MISS;
               pos = 0;
               while (!hit && pos < count) begin
                  if (ring[ring_slot(pos)] == v) begin
                     swap_with_front(pos);
                     hit             = 1'b1;
                     r.removed_count = 1;
                     r.status        = ST_OK;
                  end else begin
                     pos++;
                  end
               end
            end
            ACT_REMOVE_ALL: begin
               // after a swap the next unchecked entry sits at the same position
               pos = 0;
               while (pos < count) begin
                  if (ring[ring_slot(pos)] == v) begin
                     swap_with_front(pos);
                     r.removed_count = r.removed_count + 1'b1;
                  end else begin
                     pos++;
                  end
               end
               r.status = (r.removed_count != 0) ? ST_OK : ST_MISS;
            end
            default: begin
               count = 0;
            end
         endcase
         r.fill_level = COUNT_W'(count);
         if (count != 0) begin
            r.front_value = ring[front];
            r.back_value  = ring[ring_slot(count - 1)];
         end
         return r;
      endfunction

      function void note_request(action_type act, logic [ITEM_W-1:0] v);
         expected_replies.push_back(predict_reply(act, v));
      endfunction

      function void compare_field(string name, logic [ITEM_W-1:0] exp_val,
                                  logic [ITEM_W-1:0] act_val);
         if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            error_count++;
         end
      endfunction

      function void check_reply(deque_reply_type got);
         deque_reply_type want;
         if (expected_replies.size() == 0) begin
            $error("reply beat with no request outstanding");
            error_count++;
            return;
         end
         want = expected_replies.pop_front();
         compare_field("status",        ITEM_W'(want.status),        ITEM_W'(got.status));
         compare_field("taken_value",   want.taken_value,            got.taken_value);
         compare_field("found_index",   ITEM_W'(want.found_index),   ITEM_W'(got.found_index));
         compare_field("removed_count", ITEM_W'(want.removed_count), ITEM_W'(got.removed_count));
         compare_field("fill_level",    ITEM_W'(want.fill_level),    ITEM_W'(got.fill_level));
         compare_field("front_value",   want.front_value,            got.front_value);
         compare_field("back_value",    want.back_value,             got.back_value);
      endfunction

      function int unsigned pending();
         return expected_replies.size();
      endfunction
   endclass

endpackage : deque_scoreboard_pkg

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the bounded deque with a directed opening (empty and full corners,
// every action, duplicate values) and then biased random traffic that fills,
// drains and searches the deque, with random idle bursts on both channels.
// ----------------------------------------------------------------------------

module testbench;
   import bdq_pkg::*;
   import deque_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_ITEMS  = 300;
   localparam int CYCLE_LIMIT  = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idling_on = 1'b1;
   int unsigned cycle_count = 0;
   logic [ITEM_W-1:0] value_pool [4];

   bdq_req_if req_chan ();
   bdq_rsp_if rsp_chan ();

   deque_scoreboard sb = new();

   bounded_deque_with_search DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // watch both channels: note accepted requests, check accepted replies
   always @(posedge clock) begin
      deque_reply_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(action_type'(req_chan.action), req_chan.item_value);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status        = status_type'(rsp_chan.status);
            got.taken_value   = rsp_chan.taken_value;
            got.found_index   = rsp_chan.found_index;
            got.removed_count = rsp_chan.removed_count;
            got.fill_level    = rsp_chan.fill_level;
            got.front_value   = rsp_chan.front_value;
            got.back_value    = rsp_chan.back_value;
            sb.check_reply(got);
         end
      end
   end

   // reply back-pressure in random bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // one request beat; called just after a rising edge, returns at its accept edge
   task automatic send_beat(action_type act, logic [ITEM_W-1:0] v);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.item_value <= v;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic [ITEM_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6)
         return value_pool[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   // phase 0 fills, phase 1 drains, phase 2 leans on searches
   function automatic action_type pick_action(int unsigned phase);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         return ACT_CLEAR;
      case (phase)
         0: begin
            if (roll < 65) return ($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
         end
         1: begin
            if (roll < 55) return ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
         end
         default: begin
            if (roll < 30) return ($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            if (roll < 45) return ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
         end
      endcase
      case ($urandom_range(0, 6))
         0:       return ACT_PUSH_FRONT;
         1:       return ACT_PUSH_BACK;
         2:       return ACT_POP_FRONT;
         3:       return ACT_POP_BACK;
         4:       return ACT_FIND;
         5:       return ACT_REMOVE_ONE;
         default: return ACT_REMOVE_ALL;
      endcase
   endfunction

   initial begin
      int unsigned k;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_CLEAR;
      req_chan.item_value <= '0;
      value_pool[0] = '0;
      value_pool[1] = '1;
      value_pool[2] = $urandom();
      value_pool[3] = $urandom();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty deque corners
      send_beat(ACT_POP_FRONT, '0);
      send_beat(ACT_POP_BACK, '1);
      send_beat(ACT_FIND, '0);
      send_beat(ACT_REMOVE_ONE, '1);
      send_beat(ACT_REMOVE_ALL, '0);

      // fill to the brim from both ends, with repeated values
      for (k = 0; k < RING_DEPTH; k++)
         send_beat((k % 2 != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, value_pool[k % 3]);
      send_beat(ACT_PUSH_FRONT, 32'h1234_5678);
      send_beat(ACT_PUSH_BACK, 32'h8765_4321);

      // searches and removes on a full deque
      send_beat(ACT_FIND, '1);
      send_beat(ACT_REMOVE_ONE, '0);
      send_beat(ACT_REMOVE_ALL, value_pool[2]);
      send_beat(ACT_FIND, 32'h5555_AAAA);
      send_beat(ACT_POP_BACK, '0);
      send_beat(ACT_POP_FRONT, '0);
      send_beat(ACT_CLEAR, '1);

      // biased random traffic; the last stretch runs without idling
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 200 == 199) begin
            value_pool[2] = $urandom();
            value_pool[3] = $urandom();
         end
         if (k == RANDOM_ITEMS - QUIET_ITEMS)
            idling_on = 1'b0;
         send_beat(pick_action((k / 40) % 3), pick_value());
      end
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (sb.error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule : testbench

// ===== filelist.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_req_if.sv
hw/rtl/bdq_rsp_if.sv
hw/rtl/bdq_store.sv
hw/rtl/bounded_deque_with_search.sv
bench/deque_scoreboard_pkg.sv
bench/testbench.sv
